// ----- design/vital_sign_outlier_smoother_macros.svh -----
// Assertion macros shared by the vital-sign smoother RTL.
// Each macro expects signals clk and rst_n in the including module.
`ifndef VITAL_SIGN_OUTLIER_SMOOTHER_MACROS_SVH
`define VITAL_SIGN_OUTLIER_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSOS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSOS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vsos_pkg.sv -----
// Package for the vital-sign outlier smoother: field widths, register
// indexes, register reset values and the configuration bundle type.
// No dependencies.
package vsos_pkg;

    localparam int VAL_W      = 10;  // stored reading / average width
    localparam int IN_W       = 11;  // two's complement reading width
    localparam int MARGIN_W   = 8;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_HR_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HR_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPO2_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECHECK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd5;

    localparam logic [VAL_W-1:0]    RST_HR_LOW   = 10'd60;
    localparam logic [VAL_W-1:0]    RST_HR_HIGH  = 10'd150;
    localparam logic [VAL_W-1:0]    RST_SPO2_LOW = 10'd80;
    localparam logic [MARGIN_W-1:0] RST_MARGIN   = 8'd10;
    localparam logic [COUNT_W-1:0]  RST_RECHECK  = 4'd4;
    localparam logic [COUNT_W-1:0]  RST_TIMEOUT  = 4'd4;

    typedef struct packed {
        logic [VAL_W-1:0]    hr_low_limit;
        logic [VAL_W-1:0]    hr_high_limit;
        logic [VAL_W-1:0]    spo2_low_limit;
        logic [MARGIN_W-1:0] outlier_margin;
        logic [COUNT_W-1:0]  recheck_count;
        logic [COUNT_W-1:0]  timeout_count;
    } cfg_t;

endpackage

// ----- design/vsos_cfg.sv -----
// Configuration register bank for the vital-sign smoother.
// Depends on vsos_pkg for register indexes, reset values and cfg_t.
module vsos_cfg
    import vsos_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HR_LOW:   cfg_next.hr_low_limit   = cfg_data;
                REG_HR_HIGH:  cfg_next.hr_high_limit  = cfg_data;
                REG_SPO2_LOW: cfg_next.spo2_low_limit = cfg_data;
                REG_MARGIN:   cfg_next.outlier_margin = cfg_data[MARGIN_W-1:0];
                REG_RECHECK:  cfg_next.recheck_count  = cfg_data[COUNT_W-1:0];
                REG_TIMEOUT:  cfg_next.timeout_count  = cfg_data[COUNT_W-1:0];
                default:      cfg_next = cfg_reg;  // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hr_low_limit   <= RST_HR_LOW;
            cfg_reg.hr_high_limit  <= RST_HR_HIGH;
            cfg_reg.spo2_low_limit <= RST_SPO2_LOW;
            cfg_reg.outlier_margin <= RST_MARGIN;
            cfg_reg.recheck_count  <= RST_RECHECK;
            cfg_reg.timeout_count  <= RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/vsos_chan.sv -----
// One smoothing channel: history shift line, running window sums, run
// counters and average. Depends on vsos_pkg and the shared assertion macros.
`include "vital_sign_outlier_smoother_macros.svh"
module vsos_chan
    import vsos_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16,
    parameter int RECENT_WINDOW = 4,
    parameter bit UPWARD        = 1'b1   // 1: drop high outliers, 0: drop low ones
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,      // request accepted this cycle
    input  logic             acc,       // reading valid and within limits
    input  logic [VAL_W-1:0] value,
    input  cfg_t             cfg,
    output logic             taken,
    output logic [VAL_W-1:0] avg       // average after this request
);

    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int NW     = $clog2(HISTORY_DEPTH + 1) - 1;  // windows 2, 4, .. 2**NW
    localparam int SUM_W  = VAL_W + NW;
    localparam int WIN    = (RECENT_WINDOW < HISTORY_DEPTH) ? RECENT_WINDOW : HISTORY_DEPTH;

    logic [VAL_W-1:0]   hist_reg  [HISTORY_DEPTH];
    logic [VAL_W-1:0]   hist_next [HISTORY_DEPTH];
    logic [SUM_W-1:0]   sum_reg   [NW];
    logic [SUM_W-1:0]   sum_next  [NW];
    logic [SUM_W-1:0]   sum_shift [NW];
    logic [FILL_W-1:0]  fill_reg, fill_next, fill_inc;
    logic [COUNT_W-1:0] valid_run_reg, valid_run_next;
    logic [COUNT_W-1:0] reject_run_reg, reject_run_next;
    logic [VAL_W-1:0]   avg_reg, avg_next, avg_calc;
    logic               outlier;
    logic               check;
    logic               keep;

    always_comb
    begin
        outlier = 1'b1;
        for (int i = 0; i < WIN; i++)
        begin
            if (UPWARD)
            begin
                if ({1'b0, value} < ({1'b0, hist_reg[i]} + {3'b000, cfg.outlier_margin}))
                    outlier = 1'b0;
            end
            else
            begin
                if (({1'b0, value} + {3'b000, cfg.outlier_margin}) > {1'b0, hist_reg[i]})
                    outlier = 1'b0;
            end
        end
    end

    assign check = (valid_run_reg == cfg.recheck_count);
    assign keep  = acc && !(check && outlier);
    assign taken = keep;

    // Window sums, history, fill and average after a push: add the new reading, drop the entry leaving the window.
    always_comb
    begin
        for (int j = 0; j < NW; j++)
            sum_shift[j] = sum_reg[j] + SUM_W'(value) - SUM_W'(hist_reg[(2 << j) - 1]);
        hist_next[0] = value;
        for (int i = 1; i < HISTORY_DEPTH; i++)
            hist_next[i] = hist_reg[i - 1];
        fill_inc = (fill_reg < FILL_W'(HISTORY_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        avg_calc = '0;
        for (int j = 0; j < NW; j++)
        begin
            if (fill_inc >= FILL_W'(2 << j))
                avg_calc = VAL_W'(sum_shift[j] >> (j + 1));
        end
    end

    always_comb
    begin
        valid_run_next  = valid_run_reg;
        reject_run_next = reject_run_reg;
        fill_next       = fill_reg;
        avg_next        = avg_reg;
        sum_next        = sum_reg;
        if (!acc)
        begin
            valid_run_next = '0;
            if (reject_run_reg == cfg.timeout_count)
            begin
                // timeout: clear fill and average, keep history
                fill_next = '0;
                avg_next  = '0;
            end
            else
            begin
                reject_run_next = reject_run_reg + 1'b1;
            end
        end
        else
        begin
            reject_run_next = '0;
            if (check)
            begin
                if (outlier)
                    valid_run_next = '0;
            end
            else
            begin
                valid_run_next = valid_run_reg + 1'b1;
            end
            if (keep)
            begin
                fill_next = fill_inc;
                avg_next  = avg_calc;
                sum_next  = sum_shift;
            end
        end
    end

    assign avg = avg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
            for (int j = 0; j < NW; j++)
                sum_reg[j] <= '0;
            fill_reg       <= '0;
            valid_run_reg  <= '0;
            reject_run_reg <= '0;
            avg_reg        <= '0;
        end
        else if (step)
        begin
            if (keep)
                hist_reg <= hist_next;
            sum_reg        <= sum_next;
            fill_reg       <= fill_next;
            valid_run_reg  <= valid_run_next;
            reject_run_reg <= reject_run_next;
            avg_reg        <= avg_next;
        end
    end

    `VSOS_ASSERT_NOW(a_taken_needs_acc, taken, acc, "reading taken without passing limits")
    `VSOS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(HISTORY_DEPTH), "fill past depth")
    `VSOS_ASSERT_NEXT(a_timeout_clears, step && !acc && (reject_run_reg == cfg.timeout_count), (fill_reg == '0) && (avg_reg == '0), "timeout did not clear fill and average")
    `VSOS_ASSERT_NEXT(a_push_newest, step && keep, hist_reg[0] == $past(value), "kept reading not at head of history")

endmodule

// ----- design/vital_sign_outlier_smoother.sv -----
// Top level of the vital-sign outlier smoother: stream ports, limit checks, two smoothing
// channels and the result register. Depends on vsos_pkg, vsos_cfg and vsos_chan.
// A result sits in the output register in the cycle after its request is accepted; one
// request per cycle unless the output stalls. Limit check, outlier compare, running window
// sums and average select form one combinational pass into the state and result registers.
// Reset clears history, sums, counters, averages and result valid; registers take defaults.
module vital_sign_outlier_smoother
    import vsos_pkg::*;
#(
    parameter int HISTORY_DEPTH = 16,
    parameter int RECENT_WINDOW = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // hr_value[10:0], spo2_value[21:11], zero pad
    input  logic [1:0]            s_tuser,   // hr_ok[0], spo2_ok[1]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // hr_average[9:0], spo2_average[19:10], zero pad
    output logic [1:0]            m_tuser    // hr_taken[0], spo2_taken[1]
);

    logic [IN_W-1:0]  hr_value;
    logic [IN_W-1:0]  spo2_value;
    logic             hr_acc;
    logic             spo2_acc;
    logic             step;
    cfg_t             cfg;
    logic             hr_taken, spo2_taken;
    logic [VAL_W-1:0] hr_avg, spo2_avg;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    // Register bank; the user must write it only while the block is idle, the block does not enforce it.
    vsos_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Take a new request whenever the result register is empty or being drained.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    assign hr_value   = s_tdata[10:0];
    assign spo2_value = s_tdata[21:11];

    // Limit checks: negative readings always fail; the magnitude then fits
    // ten bits, so the compares run unsigned on the low bits.
    assign hr_acc   = s_tuser[0] && !hr_value[IN_W-1]
                      && (hr_value[VAL_W-1:0] > cfg.hr_low_limit)
                      && (hr_value[VAL_W-1:0] < cfg.hr_high_limit);
    assign spo2_acc = s_tuser[1] && !spo2_value[IN_W-1]
                      && (spo2_value[VAL_W-1:0] > cfg.spo2_low_limit);

    // Heart rate drops readings that jump above the recent history.
    vsos_chan
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .RECENT_WINDOW (RECENT_WINDOW),
        .UPWARD        (1'b1)
    )
    u_hr_chan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .acc   (hr_acc),
        .value (hr_value[VAL_W-1:0]),
        .cfg   (cfg),
        .taken (hr_taken),
        .avg   (hr_avg)
    );

    // Saturation drops readings that fall below the recent history.
    vsos_chan
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .RECENT_WINDOW (RECENT_WINDOW),
        .UPWARD        (1'b0)
    )
    u_spo2_chan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .acc   (spo2_acc),
        .value (spo2_value[VAL_W-1:0]),
        .cfg   (cfg),
        .taken (spo2_taken),
        .avg   (spo2_avg)
    );

    // Result register: load on every accepted request, clear once taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (step)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_tdata_reg <= {4'b0000, spo2_avg, hr_avg};
            m_tuser_reg <= {spo2_taken, hr_taken};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
